>>> hw/rtl/nmea_rmc_pkg.sv
// ----------------------------------------------------------------------------
// nmea_rmc_pkg
// Shared constants, operation codes and types for the RMC position extractor.
// ----------------------------------------------------------------------------
package nmea_rmc_pkg;

    // framing
    localparam int LINE_LIMIT   = 127;
    localparam int CHAR_CNT_W   = $clog2(LINE_LIMIT + 1);
    localparam int PREFIX_LEN   = 6;

    // field capture
    localparam int FIELD_CHARS  = 7;
    localparam int BYTE_W       = 8;
    localparam int TEXT_W       = FIELD_CHARS * BYTE_W;
    localparam int LEN_W        = 3;
    localparam int COMMA_W      = 4;
    localparam logic [COMMA_W-1:0] COMMA_MAX  = 4'd15;
    localparam logic [COMMA_W-1:0] LAT_COMMAS = 4'd3;
    localparam logic [COMMA_W-1:0] LON_COMMAS = 4'd5;

    // character codes
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;

    // operation queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_LAT_CHAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LON_CHAR = 2'd1;
    localparam logic [OP_W-1:0] OP_END_DROP = 2'd2;
    localparam logic [OP_W-1:0] OP_END_EMIT = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   kind;
        logic [BYTE_W-1:0] data;
    } t_op;

    // expected character at each prefix position of "$GPRMC"
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] ch;
        begin
            case (pos)
                3'd0:    ch = 8'h24; // $
                3'd1:    ch = 8'h47; // G
                3'd2:    ch = 8'h50; // P
                3'd3:    ch = 8'h52; // R
                3'd4:    ch = 8'h4D; // M
                3'd5:    ch = 8'h43; // C
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

>>> hw/rtl/nmea_rmc_front.sv
// ----------------------------------------------------------------------------
// nmea_rmc_front
// Accepts received bytes, frames lines, tracks the prefix and comma count,
// and turns each relevant byte into an operation for the back end.
// ----------------------------------------------------------------------------
module nmea_rmc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [nmea_rmc_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                                o_stall,
    input  logic                                i_queue_full,
    output logic                                o_push,
    output nmea_rmc_pkg::t_op                   o_op
);

    logic [nmea_rmc_pkg::CHAR_CNT_W-1:0] r_char_cnt, n_char_cnt;
    logic                                r_prefix_ok, n_prefix_ok;
    logic [nmea_rmc_pkg::COMMA_W-1:0]    r_comma_idx, n_comma_idx;
    logic                                accept;
    logic                                line_end;
    logic                                is_comma;

    assign o_stall  = i_queue_full;
    assign accept   = i_valid && !i_queue_full;
    assign line_end = (i_rx_byte == nmea_rmc_pkg::CHAR_LF) ||
                      (r_char_cnt >= nmea_rmc_pkg::CHAR_CNT_W'(nmea_rmc_pkg::LINE_LIMIT));
    assign is_comma = (i_rx_byte == nmea_rmc_pkg::CHAR_COMMA);

    // line state update and op classification
    always_comb begin
        n_char_cnt  = r_char_cnt;
        n_prefix_ok = r_prefix_ok;
        n_comma_idx = r_comma_idx;
        o_push      = 1'b0;
        o_op.kind   = nmea_rmc_pkg::OP_END_DROP;
        o_op.data   = i_rx_byte;
        if (accept) begin
            if (line_end) begin
                o_push      = 1'b1;
                o_op.kind   = (r_prefix_ok && r_char_cnt >=
                               nmea_rmc_pkg::CHAR_CNT_W'(nmea_rmc_pkg::PREFIX_LEN))
                              ? nmea_rmc_pkg::OP_END_EMIT : nmea_rmc_pkg::OP_END_DROP;
                n_char_cnt  = '0;
                n_prefix_ok = 1'b1;
                n_comma_idx = '0;
            end else begin
                if (r_char_cnt < nmea_rmc_pkg::CHAR_CNT_W'(nmea_rmc_pkg::PREFIX_LEN) &&
                    i_rx_byte != nmea_rmc_pkg::prefix_char(r_char_cnt[2:0])) begin
                    n_prefix_ok = 1'b0;
                end
                if (is_comma) begin
                    if (r_comma_idx != nmea_rmc_pkg::COMMA_MAX) begin
                        n_comma_idx = r_comma_idx + 1'b1;
                    end
                end else if (r_comma_idx == nmea_rmc_pkg::LAT_COMMAS) begin
                    o_push    = 1'b1;
                    o_op.kind = nmea_rmc_pkg::OP_LAT_CHAR;
                end else if (r_comma_idx == nmea_rmc_pkg::LON_COMMAS) begin
                    o_push    = 1'b1;
                    o_op.kind = nmea_rmc_pkg::OP_LON_CHAR;
                end
                n_char_cnt = r_char_cnt + 1'b1;
            end
        end
    end

    // line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_cnt  <= '0;
            r_prefix_ok <= 1'b1;
            r_comma_idx <= '0;
        end else begin
            r_char_cnt  <= n_char_cnt;
            r_prefix_ok <= n_prefix_ok;
            r_comma_idx <= n_comma_idx;
        end
    end

endmodule

>>> hw/rtl/nmea_rmc_queue.sv
// ----------------------------------------------------------------------------
// nmea_rmc_queue
// Short operation queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module nmea_rmc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  nmea_rmc_pkg::t_op   i_op,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output nmea_rmc_pkg::t_op   o_head
);

    nmea_rmc_pkg::t_op                   r_mem [nmea_rmc_pkg::QUEUE_DEPTH];
    logic [nmea_rmc_pkg::QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [nmea_rmc_pkg::QUEUE_CW-1:0]   r_count;

    assign o_full  = (r_count == nmea_rmc_pkg::QUEUE_CW'(nmea_rmc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // no push into a full queue, no pop from an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= nmea_rmc_pkg::QUEUE_CW'(nmea_rmc_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> hw/rtl/nmea_rmc_back.sv
// ----------------------------------------------------------------------------
// nmea_rmc_back
// Executes queued operations: captures latitude and longitude characters and
// loads the result register at the end of an RMC line.
// ----------------------------------------------------------------------------
module nmea_rmc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  nmea_rmc_pkg::t_op                   i_head,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [nmea_rmc_pkg::TEXT_W-1:0]     o_latitude_text,
    output logic [nmea_rmc_pkg::LEN_W-1:0]      o_latitude_length,
    output logic [nmea_rmc_pkg::TEXT_W-1:0]     o_longitude_text,
    output logic [nmea_rmc_pkg::LEN_W-1:0]      o_longitude_length
);

    logic [nmea_rmc_pkg::TEXT_W-1:0] r_lat_text, n_lat_text;
    logic [nmea_rmc_pkg::LEN_W-1:0]  r_lat_cnt,  n_lat_cnt;
    logic [nmea_rmc_pkg::TEXT_W-1:0] r_lon_text, n_lon_text;
    logic [nmea_rmc_pkg::LEN_W-1:0]  r_lon_cnt,  n_lon_cnt;
    logic                            r_out_valid;
    logic [nmea_rmc_pkg::TEXT_W-1:0] r_out_lat_text, r_out_lon_text;
    logic [nmea_rmc_pkg::LEN_W-1:0]  r_out_lat_len,  r_out_lon_len;
    logic                            out_free;
    logic                            is_emit;
    logic                            load_out;

    assign out_free = !r_out_valid || !i_stall;
    assign is_emit  = (i_head.kind == nmea_rmc_pkg::OP_END_EMIT);
    assign o_pop    = !i_empty && (!is_emit || out_free);
    assign load_out = o_pop && is_emit;

    // capture update per operation
    always_comb begin
        n_lat_text = r_lat_text;
        n_lat_cnt  = r_lat_cnt;
        n_lon_text = r_lon_text;
        n_lon_cnt  = r_lon_cnt;
        if (o_pop) begin
            unique case (i_head.kind)
                nmea_rmc_pkg::OP_LAT_CHAR: begin
                    if (r_lat_cnt < nmea_rmc_pkg::LEN_W'(nmea_rmc_pkg::FIELD_CHARS)) begin
                        for (int i = 0; i < nmea_rmc_pkg::FIELD_CHARS; i++) begin
                            if (r_lat_cnt == nmea_rmc_pkg::LEN_W'(i)) begin
                                n_lat_text[i*nmea_rmc_pkg::BYTE_W +: nmea_rmc_pkg::BYTE_W] =
                                    i_head.data;
                            end
                        end
                        n_lat_cnt = r_lat_cnt + 1'b1;
                    end
                end
                nmea_rmc_pkg::OP_LON_CHAR: begin
                    if (r_lon_cnt < nmea_rmc_pkg::LEN_W'(nmea_rmc_pkg::FIELD_CHARS)) begin
                        for (int i = 0; i < nmea_rmc_pkg::FIELD_CHARS; i++) begin
                            if (r_lon_cnt == nmea_rmc_pkg::LEN_W'(i)) begin
                                n_lon_text[i*nmea_rmc_pkg::BYTE_W +: nmea_rmc_pkg::BYTE_W] =
                                    i_head.data;
                            end
                        end
                        n_lon_cnt = r_lon_cnt + 1'b1;
                    end
                end
                nmea_rmc_pkg::OP_END_DROP,
                nmea_rmc_pkg::OP_END_EMIT: begin
                    n_lat_text = '0;
                    n_lat_cnt  = '0;
                    n_lon_text = '0;
                    n_lon_cnt  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // capture registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_text <= '0;
            r_lat_cnt  <= '0;
            r_lon_text <= '0;
            r_lon_cnt  <= '0;
        end else begin
            r_lat_text <= n_lat_text;
            r_lat_cnt  <= n_lat_cnt;
            r_lon_text <= n_lon_text;
            r_lon_cnt  <= n_lon_cnt;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_lat_text <= r_lat_text;
            r_out_lat_len  <= r_lat_cnt;
            r_out_lon_text <= r_lon_text;
            r_out_lon_len  <= r_lon_cnt;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_latitude_text    = r_out_lat_text;
    assign o_latitude_length  = r_out_lat_len;
    assign o_longitude_text   = r_out_lon_text;
    assign o_longitude_length = r_out_lon_len;

    // an emitting line end always shows up as a word
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> r_out_valid)
        else $error("line end did not load output word");

    // a held word is never overwritten by the next line end
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !load_out)
        else $error("stalled output word overwritten");

    // capture counts stay within the field size
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lat_cnt <= nmea_rmc_pkg::LEN_W'(nmea_rmc_pkg::FIELD_CHARS) &&
        r_lon_cnt <= nmea_rmc_pkg::LEN_W'(nmea_rmc_pkg::FIELD_CHARS))
        else $error("capture count beyond field size");

endmodule

>>> hw/rtl/nmea_rmc_position_extractor_core.sv
// ----------------------------------------------------------------------------
// nmea_rmc_position_extractor_core
// Frames received serial bytes into lines and reports the latitude and
// longitude fields of every "$GPRMC" line.
//
// Input channel: one received byte per word on i_rx_byte, taken when i_valid
// is high and o_stall is low. Up to one byte is accepted every cycle.
// Output channel: one word per "$GPRMC" line, offered on o_valid with the
// captured latitude and longitude text (first character in the low byte,
// unused bytes zero) and their lengths, taken when i_stall is low.
// A line ends at a newline or at the byte after 127 stored characters; that
// byte is dropped. Lines that do not start with "$GPRMC" give no word.
// The line-ending byte becomes an operation in the queue; once those ahead of
// it are done and the output word is free, it loads the output word register.
// Throughput: one byte per cycle unless o_stall, set by the front line tracker;
// only capture and line-end bytes enter the four-entry operation queue.
// When the receiver stalls, the output word holds, the back end stops at the
// next line end that gives a word, the queue fills and o_stall then rises.
// Reset (synchronous, active low) clears the line state, the queue and the
// output valid; the block accepts bytes as soon as reset is released.
// ----------------------------------------------------------------------------
module nmea_rmc_position_extractor_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [nmea_rmc_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                                o_stall,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [nmea_rmc_pkg::TEXT_W-1:0]     o_latitude_text,
    output logic [nmea_rmc_pkg::LEN_W-1:0]      o_latitude_length,
    output logic [nmea_rmc_pkg::TEXT_W-1:0]     o_longitude_text,
    output logic [nmea_rmc_pkg::LEN_W-1:0]      o_longitude_length
);

    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_empty;
    nmea_rmc_pkg::t_op push_op;
    nmea_rmc_pkg::t_op head_op;

    // line framing and classification
    nmea_rmc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_rx_byte    (i_rx_byte),
        .o_stall      (o_stall),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_op         (push_op)
    );

    // operation queue
    nmea_rmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_head  (head_op)
    );

    // field capture and output word
    nmea_rmc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (queue_empty),
        .i_head             (head_op),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_latitude_text    (o_latitude_text),
        .o_latitude_length  (o_latitude_length),
        .o_longitude_text   (o_longitude_text),
        .o_longitude_length (o_longitude_length)
    );

endmodule
